// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL. All checks are clocked on clk and
// are switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PRN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define PRN_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== sv/prn_pkg.sv =====
package prn_pkg;

  localparam int SRC_HEIGHT  = 64;
  localparam int SRC_WIDTH   = 128;
  localparam int OUT_HEIGHT  = 128;
  localparam int OUT_WIDTH   = 128;
  localparam int FRAME_DEPTH = SRC_HEIGHT * SRC_WIDTH;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);

  localparam int PIX_W  = 8;
  localparam int IDX_W  = 8;
  localparam int COEF_W = 40;
  localparam int X_W    = IDX_W + 2;
  localparam int PROD_W = COEF_W + X_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int Q_W    = 16;
  localparam int FRAC_W = 8;
  localparam int DIV_W  = SUM_W + Q_W;
  localparam int DIV_LAT = Q_W + 1;
  localparam int NUM_REGS = 8;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    coef_t xx;
    coef_t xy;
    coef_t xc;
    coef_t yx;
    coef_t yy;
    coef_t yc;
    coef_t wx;
    coef_t wy;
  } coef_set_t;

  localparam coef_t RST_XX = 40'sd24343606;
  localparam coef_t RST_XY = -40'sd24787112;
  localparam coef_t RST_XC = 40'sd2133741430;
  localparam coef_t RST_YX = 40'sd29221800;
  localparam coef_t RST_YY = 40'sd7539546;
  localparam coef_t RST_YC = -40'sd627230816;
  localparam coef_t RST_WX = -40'sd4024;
  localparam coef_t RST_WY = -40'sd781;

  localparam sum_t ONE_Q24 = sum_t'(1) <<< 24;

  typedef enum logic [$clog2(NUM_REGS)-1:0] {
    REG_XX, REG_XY, REG_XC, REG_YX, REG_YY, REG_YC, REG_WX, REG_WY
  } reg_idx_t;

  // Sideband of one word as it moves down the pipeline.
  typedef struct packed {
    logic             func;
    logic             ok;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [PIX_W-1:0] pix;
  } prn_item_t;

endpackage

// ===== sv/prn_ram.sv =====
module prn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/prn_affine.sv =====
module prn_affine
  import prn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  prn_item_t in_item,
  input  coef_set_t coefs,
  output logic      out_valid,
  output prn_item_t out_item,
  output sum_t      nx,
  output sum_t      ny,
  output sum_t      den
);

  logic signed [X_W-1:0] x, y;
  logic signed [PROD_W-1:0] p_xx, p_xy, p_yx, p_yy, p_wx, p_wy;
  coef_t     c_xc, c_yc;
  logic      a_valid;
  prn_item_t a_item;

  assign x = $signed({2'b00, in_item.col}) + X_W'(1);
  assign y = $signed({2'b00, in_item.row}) + X_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      out_valid <= a_valid;
    end
  end

  // First stage: the six products. Second stage: the three sums.
  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= in_item;
      p_xx   <= coefs.xx * x;
      p_xy   <= coefs.xy * y;
      p_yx   <= coefs.yx * x;
      p_yy   <= coefs.yy * y;
      p_wx   <= coefs.wx * x;
      p_wy   <= coefs.wy * y;
      c_xc   <= coefs.xc;
      c_yc   <= coefs.yc;
      out_item <= a_item;
      nx  <= sum_t'(p_xx) + sum_t'(p_xy) + sum_t'(c_xc);
      ny  <= sum_t'(p_yx) + sum_t'(p_yy) + sum_t'(c_yc);
      den <= sum_t'(p_wx) + sum_t'(p_wy) + ONE_Q24;
    end
  end

endmodule

// ===== sv/prn_divider.sv =====
module prn_divider
  import prn_pkg::*;
(
  input  logic           clk,
  input  logic           en,
  input  sum_t           num,
  input  sum_t           den,
  output logic           bad,
  output logic [Q_W-1:0] quo
);

  // One quotient bit per stage, most significant first. The entry stage
  // flags a negative numerator, a non-positive denominator and a quotient
  // that would not fit in Q_W bits.
  logic [DIV_W-1:0] rem   [Q_W+1];
  logic [DIV_W-1:0] dsr   [Q_W+1];
  logic [Q_W-1:0]   qs    [Q_W+1];
  logic             bad_s [Q_W+1];

  logic [DIV_W-1:0] num_u, den_u;

  assign num_u = DIV_W'($unsigned(num));
  assign den_u = DIV_W'($unsigned(den));

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= num_u << FRAC_W;
      dsr[0]   <= den_u;
      qs[0]    <= '0;
      bad_s[0] <= num[SUM_W-1] | den[SUM_W-1] | (den == '0) |
                  (num_u >= (den_u << FRAC_W));
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_bit
    localparam int B = Q_W - 1 - k;
    logic [DIV_W-1:0] trial;
    logic             take;

    assign trial = dsr[k] << B;
    assign take  = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]   <= take ? rem[k] - trial : rem[k];
        dsr[k+1]   <= dsr[k];
        bad_s[k+1] <= bad_s[k];
        qs[k+1]    <= qs[k] | (take ? (Q_W'(1) << B) : '0);
      end
    end
  end

  assign bad = bad_s[Q_W];
  assign quo = qs[Q_W];

endmodule

// ===== sv/perspective_remap_nearest.sv =====
// Inverse perspective remap with nearest-neighbor sampling.
// Input stream: tuser is func (0 writes a source pixel, 1 maps an output
// pixel); tdata carries row, col and the pixel to store. Writes make no
// output word; each map word makes exactly one output word, in order.
// Output stream: tdata carries the sampled pixel and its source row and
// column, tuser is the inside flag; outside points return all zeros.
// The cfg channel writes the eight Q15.24 homography coefficients and is
// always ready; write it only while the pipeline is empty.
// From acceptance to the output register a word passes two multiply/add
// stages, one check stage plus sixteen one-bit divider stages, an index
// stage and the frame-memory read stage. One word is taken per cycle unless
// the receiver stalls with a word held. A source write lands in the frame
// memory at the read stage, so it is ordered against earlier and later map words.
// When the receiver stalls with a word held, the whole pipeline freezes and
// s_axis_tready falls in the same cycle. Reset empties the pipeline and
// restores the default coefficients; the source frame is not cleared.
module perspective_remap_nearest
  import prn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // row, col, pixel_in
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // pixel_out, src_row, src_col
  output logic        m_axis_tuser,   // inside_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [$clog2(NUM_REGS)-1:0] cfg_index,
  input  logic [COEF_W-1:0] cfg_data
);

  coef_set_t coefs;
  logic      advance;
  prn_item_t in_item;

  logic      a_valid;
  prn_item_t a_item;
  sum_t      nx, ny, den;

  logic             bad_x, bad_y;
  logic [Q_W-1:0]   qx, qy;
  logic [DIV_LAT-1:0] dl_valid;
  prn_item_t        dl_item [DIV_LAT];

  logic               p_valid, p_func, p_ok, p_inside;
  logic [IDX_W-1:0]   p_sr, p_sc;
  logic [PIX_W-1:0]   p_pix;
  logic [ADDR_W-1:0]  p_addr;

  logic               o_valid, o_inside;
  logic [IDX_W-1:0]   o_sr, o_sc;
  logic [PIX_W-1:0]   ram_q;
  logic               ram_wr;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= '{RST_XX, RST_XY, RST_XC, RST_YX, RST_YY, RST_YC, RST_WX, RST_WY};
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_XX:  coefs.xx <= cfg_data;
        REG_XY:  coefs.xy <= cfg_data;
        REG_XC:  coefs.xc <= cfg_data;
        REG_YX:  coefs.yx <= cfg_data;
        REG_YY:  coefs.yy <= cfg_data;
        REG_YC:  coefs.yc <= cfg_data;
        REG_WX:  coefs.wx <= cfg_data;
        REG_WY:  coefs.wy <= cfg_data;
        default: coefs <= coefs;
      endcase
    end
  end

  assign advance       = !o_valid || m_axis_tready;
  assign s_axis_tready = advance;

  // For a write, ok means the pixel lies in the source frame; for a map,
  // that the output coordinate lies in the output frame.
  always_comb begin
    in_item.func = s_axis_tuser;
    in_item.row  = s_axis_tdata[7:0];
    in_item.col  = s_axis_tdata[15:8];
    in_item.pix  = s_axis_tdata[23:16];
    if (s_axis_tuser) begin
      in_item.ok = ({1'b0, in_item.row} < 9'(OUT_HEIGHT)) &&
                   ({1'b0, in_item.col} < 9'(OUT_WIDTH));
    end else begin
      in_item.ok = ({1'b0, in_item.row} < 9'(SRC_HEIGHT)) &&
                   ({1'b0, in_item.col} < 9'(SRC_WIDTH));
    end
  end

  prn_affine u_affine (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (s_axis_tvalid),
    .in_item   (in_item),
    .coefs     (coefs),
    .out_valid (a_valid),
    .out_item  (a_item),
    .nx        (nx),
    .ny        (ny),
    .den       (den)
  );

  prn_divider u_div_x (
    .clk (clk),
    .en  (advance),
    .num (nx),
    .den (den),
    .bad (bad_x),
    .quo (qx)
  );

  prn_divider u_div_y (
    .clk (clk),
    .en  (advance),
    .num (ny),
    .den (den),
    .bad (bad_y),
    .quo (qy)
  );

  // Sideband delay matching the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      dl_valid <= '0;
    end else if (advance) begin
      dl_valid <= {dl_valid[DIV_LAT-2:0], a_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dl_item[0] <= a_item;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl_item[i] <= dl_item[i-1];
      end
    end
  end

  // Index stage: range check, round half up, step down by one.
  logic [Q_W:0]         rx, ry;
  logic [Q_W-FRAC_W:0]  ix, iy;
  logic                 in_x, in_y, inside_c;
  prn_item_t            d_item;

  assign d_item = dl_item[DIV_LAT-1];
  assign rx = {1'b0, qx} + (Q_W+1)'(1 << (FRAC_W - 1));
  assign ry = {1'b0, qy} + (Q_W+1)'(1 << (FRAC_W - 1));
  assign ix = rx[Q_W:FRAC_W] - (Q_W-FRAC_W+1)'(1);
  assign iy = ry[Q_W:FRAC_W] - (Q_W-FRAC_W+1)'(1);
  assign in_x = !bad_x && (qx >= Q_W'(1 << FRAC_W)) &&
                ({1'b0, qx} < (Q_W+1)'(SRC_WIDTH << FRAC_W));
  assign in_y = !bad_y && (qy >= Q_W'(1 << FRAC_W)) &&
                ({1'b0, qy} < (Q_W+1)'(SRC_HEIGHT << FRAC_W));
  assign inside_c = d_item.func && d_item.ok && in_x && in_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (advance) begin
      p_valid <= dl_valid[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_func   <= d_item.func;
      p_ok     <= d_item.ok;
      p_inside <= inside_c;
      p_pix    <= d_item.pix;
      p_sr     <= inside_c ? iy[IDX_W-1:0] : '0;
      p_sc     <= inside_c ? ix[IDX_W-1:0] : '0;
      if (d_item.func) begin
        p_addr <= ADDR_W'(iy[IDX_W-1:0] * SRC_WIDTH) + ADDR_W'(ix[IDX_W-1:0]);
      end else begin
        p_addr <= ADDR_W'(d_item.row * SRC_WIDTH) + ADDR_W'(d_item.col);
      end
    end
  end

  assign ram_wr = p_valid && advance && !p_func && p_ok;

  prn_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FRAME_DEPTH)
  ) u_frame (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (p_addr),
    .wr_data (p_pix),
    .rd_en   (advance),
    .rd_addr (p_addr),
    .rd_data (ram_q)
  );

  // Output register; write words leave the pipeline here.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= p_valid && p_func;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_inside <= p_inside;
      o_sr     <= p_sr;
      o_sc     <= p_sc;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tuser  = o_inside;
  assign m_axis_tdata  = {o_sc, o_sr, (o_inside ? ram_q : {PIX_W{1'b0}})};

`include "assert_macros.svh"

  `PRN_ASSERT(a_outside_zero, (o_valid && !o_inside) |-> (m_axis_tdata == '0), "outside word not zero")
  `PRN_ASSERT(a_src_in_frame, (o_valid && o_inside) |-> ((9'(o_sr) < 9'(SRC_HEIGHT)) && (9'(o_sc) < 9'(SRC_WIDTH))), "source index beyond frame")
  `PRN_ASSERT(a_hold_on_stall, !advance |=> ($stable(p_valid) && $stable(dl_valid)), "pipeline moved while stalled")
  `PRN_NEVER(a_write_on_map, ram_wr && p_inside, "frame written by a map word")

endmodule

// ===== tb/sv/tb_perspective_remap_nearest.sv =====
module tb_perspective_remap_nearest;
  timeunit 1ns;
  timeprecision 1ps;
  import prn_pkg::*;

  typedef struct {
    logic [7:0] pix;
    logic       in_frame;
    logic [7:0] srow;
    logic [7:0] scol;
  } remap_res_t;

  class remap_board;
    longint     coef [NUM_REGS];
    logic [7:0] frame [FRAME_DEPTH];
    bit         written [FRAME_DEPTH];
    remap_res_t expected_q [$];
    int         errors;
    int         checked;
    int         hits;

    function void set_defaults();
      coef[REG_XX] = RST_XX;
      coef[REG_XY] = RST_XY;
      coef[REG_XC] = RST_XC;
      coef[REG_YX] = RST_YX;
      coef[REG_YY] = RST_YY;
      coef[REG_YC] = RST_YC;
      coef[REG_WX] = RST_WX;
      coef[REG_WY] = RST_WY;
    endfunction

    // Rounded, one-less source index, or -1 when the coordinate is off frame.
    function int to_index(longint num, longint den, int limit);
      longint q;
      if (num < 0) return -1;
      q = (num <<< 8) / den;
      if (q < 256 || q >= longint'(limit) * 256) return -1;
      return int'((q + 128) >>> 8) - 1;
    endfunction

    function remap_res_t lookup(int row, int col);
      remap_res_t r;
      longint x, y, nx, ny, d;
      int sr, sc;
      r = '{pix: 0, in_frame: 0, srow: 0, scol: 0};
      if (row >= OUT_HEIGHT || col >= OUT_WIDTH) return r;
      x = col + 1;
      y = row + 1;
      nx = coef[REG_XX] * x + coef[REG_XY] * y + coef[REG_XC];
      ny = coef[REG_YX] * x + coef[REG_YY] * y + coef[REG_YC];
      d  = coef[REG_WX] * x + coef[REG_WY] * y + (longint'(1) <<< 24);
      if (d <= 0) return r;
      sc = to_index(nx, d, SRC_WIDTH);
      sr = to_index(ny, d, SRC_HEIGHT);
      if (sc < 0 || sr < 0) return r;
      r.in_frame = 1;
      r.srow = sr[7:0];
      r.scol = sc[7:0];
      r.pix = frame[sr * SRC_WIDTH + sc];
      return r;
    endfunction

    function void note_input(bit func, int row, int col, logic [7:0] pix);
      remap_res_t r;
      if (!func) begin
        if (row < SRC_HEIGHT && col < SRC_WIDTH) begin
          frame[row * SRC_WIDTH + col] = pix;
          written[row * SRC_WIDTH + col] = 1;
        end
      end else begin
        r = lookup(row, col);
        expected_q.push_back(r);
      end
    endfunction

    function void check_result(remap_res_t act);
      remap_res_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected output word pix=%0d inside=%0d row=%0d col=%0d",
                 $time, act.pix, act.in_frame, act.srow, act.scol);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (e.in_frame) hits++;
      if (act.pix !== e.pix || act.in_frame !== e.in_frame ||
          act.srow !== e.srow || act.scol !== e.scol) begin
        $display("%0t: mismatch expected pix=%0d inside=%0d row=%0d col=%0d, actual pix=%0d inside=%0d row=%0d col=%0d",
                 $time, e.pix, e.in_frame, e.srow, e.scol,
                 act.pix, act.in_frame, act.srow, act.scol);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  reg_idx_t cfg_index = REG_XX;
  logic [COEF_W-1:0] cfg_data = '0;

  remap_board board = new();
  bit idle_en = 1;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_cnt = 0;
  int stall_cnt = 0;

  perspective_remap_nearest u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Receiver: random stall bursts plus one long hold to back the pipe up.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1;
      hold_cnt <= 400;
      m_axis_tready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      m_axis_tready <= 0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_cnt <= $urandom_range(1, 17) - 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
    end
  end

  // Inputs only change at rising edges, so the mid-cycle view is what the
  // next edge will take.
  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_result('{pix: m_axis_tdata[7:0], in_frame: m_axis_tuser,
                           srow: m_axis_tdata[15:8], scol: m_axis_tdata[23:16]});
  end

  task automatic send_word(bit func, int row, int col, logic [7:0] pix);
    bit ok;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= func;
    s_axis_tdata <= {pix, col[7:0], row[7:0]};
    do begin
      @(negedge clk);
      ok = s_axis_tready;
      @(posedge clk);
    end while (!ok);
    board.note_input(func, row, col, pix);
  endtask

  // Makes sure a map never samples a pixel that was never stored.
  task automatic send_map(int row, int col);
    remap_res_t r;
    r = board.lookup(row, col);
    if (r.in_frame && !board.written[r.srow * SRC_WIDTH + r.scol])
      send_word(0, r.srow, r.scol, $urandom_range(0, 255));
    send_word(1, row, col, $urandom_range(0, 255));
  endtask

  task automatic drain();
    if (s_axis_tvalid) s_axis_tvalid <= 0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic load_coefs(longint vals [NUM_REGS]);
    bit ok;
    drain();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1;
      cfg_index <= reg_idx_t'(i);
      cfg_data <= vals[i][COEF_W-1:0];
      do begin
        @(negedge clk);
        ok = cfg_ready;
        @(posedge clk);
      end while (!ok);
      board.coef[i] = vals[i];
    end
    cfg_valid <= 0;
  endtask

  function automatic longint rnd_range(longint lo, longint hi);
    return lo + longint'({$urandom, $urandom}) % (hi - lo + 1) * 0 +
           (longint'({$urandom, $urandom}) & 64'h7FFF_FFFF_FFFF_FFFF) % (hi - lo + 1);
  endfunction

  task automatic random_items(int n);
    int kind;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 25)
        send_word(0, $urandom_range(0, SRC_HEIGHT - 1), $urandom_range(0, SRC_WIDTH - 1),
                  $urandom_range(0, 255));
      else if (kind < 30)
        send_word(0, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      else if (kind < 88)
        send_map($urandom_range(0, OUT_HEIGHT - 1), $urandom_range(0, OUT_WIDTH - 1));
      else
        send_map($urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  function automatic void random_set(ref longint v [NUM_REGS]);
    v[REG_XX] = rnd_range(longint'(4) << 20, longint'(28) << 20);
    v[REG_XY] = rnd_range(-(longint'(1) << 22), longint'(1) << 22);
    v[REG_XC] = rnd_range(-(longint'(40) << 24), longint'(40) << 24);
    v[REG_YX] = rnd_range(-(longint'(1) << 22), longint'(1) << 22);
    v[REG_YY] = rnd_range(longint'(2) << 20, longint'(14) << 20);
    v[REG_YC] = rnd_range(-(longint'(20) << 24), longint'(20) << 24);
    v[REG_WX] = rnd_range(-60000, 30000);
    v[REG_WY] = rnd_range(-60000, 30000);
  endfunction

  localparam longint CMAX = (longint'(1) <<< 39) - 1;
  localparam longint CMIN = -(longint'(1) <<< 39);
  localparam longint ONE = longint'(1) <<< 24;

  initial begin
    longint v [NUM_REGS];
    board.set_defaults();
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Frame corners, ignored writes outside the frame, then maps with the
    // reset coefficients including output points beyond the output frame.
    send_word(0, 0, 0, 8'h00);
    send_word(0, SRC_HEIGHT - 1, SRC_WIDTH - 1, 8'hFF);
    send_word(0, SRC_HEIGHT - 1, 0, 8'hAA);
    send_word(0, 0, SRC_WIDTH - 1, 8'h55);
    send_word(0, SRC_HEIGHT, 0, 8'hFF);
    send_word(0, 255, 255, 8'hFF);
    send_word(0, 0, SRC_WIDTH, 8'h0F);
    send_map(OUT_HEIGHT, 0);
    send_map(0, OUT_WIDTH);
    send_map(255, 255);
    send_map(0, 0);
    send_map(OUT_HEIGHT - 1, OUT_WIDTH - 1);
    send_map(64, 64);

    // Half scale hits exact halves, so rounding away from zero shows.
    v = '{ONE / 2, 0, 0, 0, ONE / 2, 0, 0, 0};
    load_coefs(v);
    send_map(0, 0);
    send_map(0, 2);
    send_map(2, 4);
    send_map(OUT_HEIGHT - 1, OUT_WIDTH - 1);

    // Register extremes: a quotient too large for Q_W bits, negative numerator and a
    // non-positive denominator.
    v = '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0, 0};
    load_coefs(v);
    send_map(0, 0);
    send_map(OUT_HEIGHT - 1, OUT_WIDTH - 1);
    v = '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN};
    load_coefs(v);
    send_map(5, 5);
    v = '{ONE, 0, 0, 0, ONE, 0, CMAX, CMAX};
    load_coefs(v);
    send_map(3, 3);

    // Identity mapping with the long receiver hold in the middle.
    v = '{ONE, 0, 0, 0, ONE, 0, 0, 0};
    load_coefs(v);
    send_map(0, 0);
    send_map(SRC_HEIGHT - 1, SRC_WIDTH - 1);
    random_items(100);
    hold_req <= 1;
    random_items(200);

    for (int p = 0; p < 4; p++) begin
      random_set(v);
      load_coefs(v);
      random_items(270);
    end

    v = '{RST_XX, RST_XY, RST_XC, RST_YX, RST_YY, RST_YC, RST_WX, RST_WY};
    load_coefs(v);
    idle_en = 0;
    random_items(270);
    drain();

    $display("Checked %0d output words, %0d of them sampled the source frame.",
             board.checked, board.hits);
    $display("Covered corner writes, ignored writes, register extremes and 11 coefficient sets.");
    if (board.errors == 0 && board.expected_q.size() == 0)
      $display("tb_perspective_remap_nearest passed");
    else
      $display("tb_perspective_remap_nearest failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_perspective_remap_nearest failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/prn_pkg.sv
sv/prn_ram.sv
sv/prn_affine.sv
sv/prn_divider.sv
sv/perspective_remap_nearest.sv
tb/sv/tb_perspective_remap_nearest.sv
